// ===== src/arpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types, widths and codes of the ARP cache responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int STAMP_W = 32;
    localparam int OP_W    = 16;
    localparam int HLEN_W  = 8;
    localparam int PLEN_W  = 8;
    localparam int LEN_W   = 16;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP = 1'b0;

    localparam logic CMD_LOOKUP = 1'b0;

    localparam logic [IP_W-1:0]    BCAST_IP    = '1;
    localparam logic [MAC_W-1:0]   BCAST_MAC   = '1;
    localparam logic [OP_W-1:0]    OP_REQUEST  = 16'd1;
    localparam logic [OP_W-1:0]    OP_REPLY    = 16'd2;
    localparam logic [HLEN_W-1:0]  HW_LEN_ETH  = 8'd6;
    localparam logic [PLEN_W-1:0]  PROTO_LEN_IPV4 = 8'd4;
    localparam logic [LEN_W-1:0]   ARP_PKT_LEN = LEN_W'(8 + 2 * (6 + 4));
    localparam logic [STAMP_W-1:0] STAMP_FIRST = 32'd1;
    localparam logic [STAMP_W-1:0] STAMP_LAST  = '1;

    localparam logic [STAT_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_REPLY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_UPDATE = 3'd3;
    localparam logic [STAT_W-1:0] ST_DROP   = 3'd4;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;
    } res_t;

endpackage

// ===== src/arpc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_in_if / arpc_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface arpc_in_if import arpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [IP_W-1:0]   ip_addr;
    logic [MAC_W-1:0]  sender_mac;
    logic [IP_W-1:0]   target_ip;
    logic [OP_W-1:0]   arp_op;
    logic [HLEN_W-1:0] hw_len;
    logic [PLEN_W-1:0] proto_len;
    logic [LEN_W-1:0]  pkt_len;

    modport source (output valid, cmd, ip_addr, sender_mac, target_ip, arp_op,
                    hw_len, proto_len, pkt_len, input ready);
    modport sink (input valid, cmd, ip_addr, sender_mac, target_ip, arp_op,
                  hw_len, proto_len, pkt_len, output ready);
endinterface

interface arpc_out_if import arpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [MAC_W-1:0]  mac_out;
    logic [IP_W-1:0]   ip_out;

    modport source (output valid, status, mac_out, ip_out, input ready);
    modport sink (input valid, status, mac_out, ip_out, output ready);
endinterface

// ===== src/arpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/arpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: decodes a request word, scans the entry RAM and writes back.
// ----------------------------------------------------------------------------
module arpc_ctrl import arpc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    arpc_in_if.sink           item,
    input  logic [IP_W-1:0]   own_ip,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    output logic              mem_we,
    output logic [IDX_W-1:0]  mem_waddr,
    output entry_t            mem_wdata,
    output logic [IDX_W-1:0]  mem_raddr,
    input  entry_t            mem_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] NUM_ENT  = CNT_W'(CACHE_ENTRIES);

    logic [2:0]               state_reg, state_next;
    logic                     cmd_reg;
    logic [IP_W-1:0]          ip_reg;
    logic [MAC_W-1:0]         smac_reg;
    logic [IP_W-1:0]          tip_reg;
    logic [OP_W-1:0]          op_reg;
    logic [HLEN_W-1:0]        hlen_reg;
    logic [PLEN_W-1:0]        plen_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [CNT_W-1:0]         issue_reg, issue_next;
    logic                     eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]         eval_reg, eval_next;
    logic [IDX_W-1:0]         best_reg, best_next;
    logic [STAMP_W-1:0]       best_stamp_reg, best_stamp_next;
    logic [STAMP_W-1:0]       stamp_reg, stamp_next;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    res_t                     res_reg, res_next;
    logic                     accept;
    logic                     len_ok;
    logic                     ent_valid;
    logic                     older;

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign len_ok     = (hlen_reg == HW_LEN_ETH) && (plen_reg == PROTO_LEN_IPV4)
                        && (len_reg == ARP_PKT_LEN);
    // An entry never written reads as empty regardless of the RAM contents.
    assign ent_valid  = valid_reg[eval_reg];
    assign older      = (eval_reg == '0) || (mem_rdata.stamp < best_stamp_reg);

    assign res_valid  = (state_reg == S_RESULT);
    assign res        = res_reg;
    assign mem_raddr  = issue_reg[IDX_W-1:0];
    assign mem_waddr  = best_reg;
    assign mem_wdata  = '{stamp: stamp_reg, ip: ip_reg, mac: smac_reg};
    assign mem_we     = (state_reg == S_WRITE);

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        eval_vld_next   = 1'b0;
        eval_next       = eval_reg;
        best_next       = best_reg;
        best_stamp_next = best_stamp_reg;
        stamp_next      = stamp_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                issue_next = '0;
                best_next  = '0;
                state_next = S_RESULT;
                res_next   = '{status: ST_DROP, mac: '0, ip: '0};
                if (cmd_reg == CMD_LOOKUP)
                begin
                    if (ip_reg == BCAST_IP)
                    begin
                        res_next = '{status: ST_HIT, mac: BCAST_MAC, ip: '0};
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (len_ok && op_reg == OP_REQUEST && tip_reg == own_ip)
                begin
                    res_next = '{status: ST_REPLY, mac: smac_reg, ip: ip_reg};
                end
                else if (len_ok && op_reg == OP_REPLY)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue_reg < NUM_ENT)
                begin
                    issue_next    = issue_reg + CNT_W'(1);
                    eval_vld_next = 1'b1;
                    eval_next     = issue_reg[IDX_W-1:0];
                end
                if (eval_vld_reg)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        if (ent_valid && mem_rdata.ip == ip_reg)
                        begin
                            res_next   = '{status: ST_HIT, mac: mem_rdata.mac, ip: '0};
                            state_next = S_RESULT;
                        end
                        else if (eval_reg == LAST_IDX)
                        begin
                            res_next   = '{status: ST_MISS, mac: '0, ip: '0};
                            state_next = S_RESULT;
                        end
                    end
                    else
                    begin
                        // Victim search: first empty entry, else the oldest stamp.
                        if (!ent_valid)
                        begin
                            best_next  = eval_reg;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            if (older)
                            begin
                                best_next       = eval_reg;
                                best_stamp_next = mem_rdata.stamp;
                            end
                            if (eval_reg == LAST_IDX)
                            begin
                                state_next = S_WRITE;
                            end
                        end
                    end
                end
            end
            S_WRITE:
            begin
                valid_next[best_reg] = 1'b1;
                stamp_next = (stamp_reg == STAMP_LAST) ? STAMP_FIRST
                                                       : stamp_reg + STAMP_W'(1);
                res_next   = '{status: ST_UPDATE, mac: '0, ip: ip_reg};
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            eval_vld_reg <= 1'b0;
            stamp_reg    <= STAMP_FIRST;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            eval_vld_reg <= eval_vld_next;
            stamp_reg    <= stamp_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= item.cmd;
            ip_reg   <= item.ip_addr;
            smac_reg <= item.sender_mac;
            tip_reg  <= item.target_ip;
            op_reg   <= item.arp_op;
            hlen_reg <= item.hw_len;
            plen_reg <= item.proto_len;
            len_reg  <= item.pkt_len;
        end
        issue_reg      <= issue_next;
        eval_reg       <= eval_next;
        best_reg       <= best_next;
        best_stamp_reg <= best_stamp_next;
        res_reg        <= res_next;
    end

endmodule

// ===== src/arp_cache_responder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_responder
// IPv4 ARP cache: answers lookups, replies to requests for our address and
// learns sender bindings from ARP replies.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Word contents
//   item      in         cmd, ip_addr, sender_mac, target_ip, arp_op,
//                        hw_len, proto_len, pkt_len
//   result    out        status, mac_out, ip_out
//   cfg       in         cfg_we, cfg_idx, cfg_data (own_ip at index 0,
//                        own_mac at index 1)
//
// A broadcast lookup, a request or a dropped packet passes from acceptance
// through the decode and result states to the output register. A lookup
// or a stored reply scans the entry RAM one address per cycle (one read
// port, registered read data); a lookup ends early at its first hit, a reply
// at the first empty entry.
// Reset clears the entry valid flags at once, so no clearing pass is needed,
// and restarts the stamp counter at 1.
// The output register lets the next word be accepted while a result waits;
// that word then stalls at its own result until the register frees up.
//
module arp_cache_responder import arpc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    arpc_in_if.sink               item,
    arpc_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [IP_W-1:0]  own_ip_reg;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             out_valid_reg;
    res_t             out_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata_raw;
    entry_t           mem_rdata;

    // Only our IP matters here. The MAC register is consumed by the frame
    // builder outside this block, so index 1 writes need no storage here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (cfg_we && cfg_idx == REG_OWN_IP)
        begin
            own_ip_reg <= cfg_data[IP_W-1:0];
        end
    end

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .own_ip    (own_ip_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    arpc_ram #(
        .DEPTH  (CACHE_ENTRIES),
        .WIDTH  (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    assign mem_rdata = entry_t'(mem_rdata_raw);

    // Output register: a new result loads when the register is empty or is
    // being emptied in the same cycle.
    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.status  = out_reg.status;
    assign result.mac_out = out_reg.mac;
    assign result.ip_out  = out_reg.ip;

endmodule

// ===== src/arpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks of the ARP cache responder result channel.
// ----------------------------------------------------------------------------
module arpc_checker import arpc_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [STAT_W-1:0] status,
    input logic [MAC_W-1:0]  mac_out,
    input logic [IP_W-1:0]   ip_out
);

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(mac_out) && $stable(ip_out))
        else $error("result word changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_DROP)
        else $error("undefined status code");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_MISS || status == ST_DROP)
            |-> mac_out == '0 && ip_out == '0)
        else $error("miss or drop carries a nonzero address");

    a_hit_upd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_HIT || status == ST_UPDATE)
            |-> (status == ST_HIT && ip_out == '0)
                || (status == ST_UPDATE && mac_out == '0))
        else $error("hit or update carries an unexpected field");

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (result.status),
    .mac_out   (result.mac_out),
    .ip_out    (result.ip_out)
);
